// ===== design/heat_rk4_pkg.sv =====
// Package for the RK4 heat equation stencil block.
// Holds the shared constants, item structs, register indexes and state codes.
// No dependencies.
package heat_rk4_pkg;

	localparam int MaxPoints = 64;
	localparam int SampleBits = 32;
	localparam int IoBits = 32;
	localparam int CfgBits = 16;
	localparam int CfgIndexBits = 2;
	localparam logic [CfgBits-1:0] CourantReset = 16'd26539;
	localparam logic [CfgBits-1:0] StepCountReset = 16'd400;

	typedef enum logic [CfgIndexBits-1:0] {
		CFG_COURANT = 2'd0,
		CFG_STEPS = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STG_K1 = 2'd0,
		STG_K2 = 2'd1,
		STG_K3 = 2'd2,
		STG_SUM = 2'd3
	} stage_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD,
		ST_SHIFT,
		ST_EVAL,
		ST_MUL,
		ST_SCALE,
		ST_DIV,
		ST_OUT_RD,
		ST_OUT_SEND
	} state_t;

	typedef struct packed {
		logic signed [IoBits-1:0] sample_value;
		logic final_point;
	} in_item_t;

	typedef struct packed {
		logic signed [IoBits-1:0] result_value;
		logic last_of_row;
	} out_item_t;

endpackage

// ===== design/heat_rk4_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module heat_rk4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/heat_rk4_div3.sv =====
// Iterative floor division of a signed value by three, four quotient bits per cycle.
// No dependencies.
module heat_rk4_div3 #(
	parameter int WIDTH = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WIDTH-1:0] dividend,
	output logic                    done,
	output logic signed [WIDTH-1:0] quotient
);

	localparam int Digits = (WIDTH + 3) / 4;
	localparam int PadW = Digits * 4;
	localparam int CntW = $clog2(Digits + 1);

	logic            busy_q;
	logic            done_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic [PadW-1:0] a_q;
	logic [PadW-1:0] q_q;
	logic [1:0]      r_q;

	logic [WIDTH-1:0] dividend_u;
	logic [WIDTH-1:0] mag;
	logic [3:0]       q_digit;
	logic [1:0]       r_next;
	logic [WIDTH-1:0] q_mag;

	assign dividend_u = dividend;
	assign mag = dividend[WIDTH-1] ? (WIDTH'(2) - dividend_u) : dividend_u;

	always_comb begin
		logic [2:0] rr;
		rr = {1'b0, r_q};
		q_digit = '0;
		for (int b = 3; b >= 0; b--) begin
			rr = {rr[1:0], a_q[PadW-4+b]};
			if (rr >= 3'd3) begin
				rr = rr - 3'd3;
				q_digit[b] = 1'b1;
			end
		end
		r_next = rr[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(Digits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WIDTH-1];
			a_q <= PadW'(mag);
			q_q <= '0;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 4;
			q_q <= {q_q[PadW-5:0], q_digit};
			r_q <= r_next;
		end
	end

	assign q_mag = q_q[WIDTH-1:0];
	assign quotient = neg_q ? -$signed(q_mag) : $signed(q_mag);
	assign done = done_q;

endmodule

// ===== design/heat_equation_rk4_stencil.sv =====
// Samples are taken only in the load state. The item that ends the row starts the run,
// or sends the row straight out when the step count is zero. The run time is set by the
// shared multiply-and-round unit and the divide-by-three unit. The row then leaves one
// result at a time: each is read in ST_OUT_RD and sent from ST_OUT_SEND, which holds
// while result_stall is high. Reset clears control state and loads the register
// defaults.
module heat_equation_rk4_stencil #(
	parameter int MAX_POINTS = heat_rk4_pkg::MaxPoints,
	parameter int SAMPLE_BITS = heat_rk4_pkg::SampleBits
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  heat_rk4_pkg::in_item_t                  sample_item,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output heat_rk4_pkg::out_item_t                 result_item,
	input  logic                                    cfg_we,
	input  logic [heat_rk4_pkg::CfgIndexBits-1:0]   cfg_index,
	input  logic [heat_rk4_pkg::CfgBits-1:0]        cfg_data
);

	import heat_rk4_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int B = SAMPLE_BITS;
	localparam int LW = B + 3;
	localparam int SW = B + 5;
	localparam int MW = SW + 17;
	localparam int PW = MW + 1;
	localparam int YW = PW - 16;
	localparam int UW = YW + 1;
	localparam int XW = (B > IoBits) ? B : IoBits;
	localparam logic signed [UW-1:0] SatHi = {{(UW-B+1){1'b0}}, {(B-1){1'b1}}};
	localparam logic signed [UW-1:0] SatLo = {{(UW-B+1){1'b1}}, {(B-1){1'b0}}};
	localparam logic signed [XW-1:0] InHi = {{(XW-B+1){1'b0}}, {(B-1){1'b1}}};
	localparam logic signed [XW-1:0] InLo = {{(XW-B+1){1'b1}}, {(B-1){1'b0}}};

	function automatic logic signed [LW-1:0] lap3(input logic signed [B-1:0] lo,
		input logic signed [B-1:0] mid, input logic signed [B-1:0] hi);
		lap3 = LW'(lo) + LW'(hi) - (LW'(mid) <<< 1);
	endfunction

	state_t          state_q, state_d;
	stage_t          stg_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   loaded_q;
	logic [CW-1:0]   n_q;
	logic [AW-1:0]   o_q;
	logic [15:0]     steps_q;
	logic [CfgBits-1:0] courant_q;
	logic [CfgBits-1:0] step_count_q;

	logic signed [B-1:0] wf_q [3];
	logic signed [B-1:0] wa_q [3];
	logic signed [B-1:0] wb_q [3];
	logic signed [B-1:0] wc_q [3];
	logic signed [SW-1:0] s_q;
	logic signed [MW-1:0] p_q;

	logic [B-1:0] f_rd, a_rd, b_rd, c_rd;
	logic [AW-1:0] rd_addr;

	logic                sample_accept;
	logic signed [XW-1:0] x_in;
	logic signed [B-1:0]  sample_sat;
	logic [CW-1:0]        jm1;
	logic [AW-1:0]        i_addr;
	logic                 interior;
	logic                 run_done;
	logic                 last_out;
	logic                 adv;
	logic                 f_we;
	logic [AW-1:0]        f_waddr;
	logic [B-1:0]         f_wdata;
	logic                 row_we;
	logic                 div_start;
	logic                 div_done;
	logic signed [YW-1:0] div_q;
	logic signed [LW-1:0] lap_f, lap_a, lap_b, lap_c;
	logic signed [SW-1:0] s_d;
	logic signed [PW-1:0] p_biased;
	logic signed [YW-1:0] y_round;
	logic signed [YW-1:0] y_sel;
	logic signed [UW-1:0] u_sum;
	logic signed [B-1:0]  w_val;
	logic signed [B-1:0]  shift_f, shift_k_a, shift_k_b, shift_k_c;
	logic                 k_zero;
	logic signed [XW-1:0] out_ext;

	assign sample_stall = (state_q != ST_LOAD);
	assign sample_accept = sample_valid && !sample_stall;

	assign x_in = XW'(sample_item.sample_value);
	always_comb begin
		if (x_in > InHi) begin
			sample_sat = InHi[B-1:0];
		end else if (x_in < InLo) begin
			sample_sat = InLo[B-1:0];
		end else begin
			sample_sat = x_in[B-1:0];
		end
	end

	assign jm1 = j_q - 1'b1;
	assign i_addr = jm1[AW-1:0];
	assign interior = (j_q >= CW'(2)) && (j_q < n_q);
	assign run_done = (j_q == n_q) && (stg_q == STG_SUM) && ((steps_q + 16'd1) == step_count_q);
	assign last_out = ((CW'(o_q) + 1'b1) == n_q);
	assign rd_addr = (state_q == ST_OUT_RD || state_q == ST_OUT_SEND) ? o_q : j_q[AW-1:0];

	heat_rk4_ram #(.WIDTH(B), .DEPTH(MAX_POINTS)) u_field_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(rd_addr), .rdata(f_rd)
	);
	heat_rk4_ram #(.WIDTH(B), .DEPTH(MAX_POINTS)) u_stage1_ram (
		.clk(clk), .we(row_we && stg_q == STG_K1), .waddr(i_addr), .wdata(w_val),
		.raddr(rd_addr), .rdata(a_rd)
	);
	heat_rk4_ram #(.WIDTH(B), .DEPTH(MAX_POINTS)) u_stage2_ram (
		.clk(clk), .we(row_we && stg_q == STG_K2), .waddr(i_addr), .wdata(w_val),
		.raddr(rd_addr), .rdata(b_rd)
	);
	heat_rk4_ram #(.WIDTH(B), .DEPTH(MAX_POINTS)) u_stage3_ram (
		.clk(clk), .we(row_we && stg_q == STG_K3), .waddr(i_addr), .wdata(w_val),
		.raddr(rd_addr), .rdata(c_rd)
	);

	heat_rk4_div3 #(.WIDTH(YW)) u_div3 (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(y_round),
		.done(div_done), .quotient(div_q)
	);

	assign lap_f = lap3(wf_q[0], wf_q[1], wf_q[2]);
	assign lap_a = lap3(wa_q[0], wa_q[1], wa_q[2]);
	assign lap_b = lap3(wb_q[0], wb_q[1], wb_q[2]);
	assign lap_c = lap3(wc_q[0], wc_q[1], wc_q[2]);

	always_comb begin
		unique case (stg_q)
			STG_K1: s_d = SW'(lap_f);
			STG_K2: s_d = SW'(lap_a);
			STG_K3: s_d = SW'(lap_b);
			STG_SUM: s_d = SW'(lap_f) + (SW'(lap_a) <<< 1) + (SW'(lap_b) <<< 1) + SW'(lap_c);
			default: s_d = '0;
		endcase
	end

	always_comb begin
		unique case (stg_q)
			STG_K3: p_biased = PW'(p_q) + (PW'(1) <<< 15);
			STG_SUM: p_biased = PW'(p_q) + (PW'(3) <<< 16);
			default: p_biased = PW'(p_q) + (PW'(1) <<< 16);
		endcase
		if (stg_q == STG_K3) begin
			y_round = YW'(p_biased >>> 16);
		end else begin
			y_round = YW'(p_biased >>> 17);
		end
		y_sel = (stg_q == STG_SUM) ? div_q : y_round;
		u_sum = UW'(wf_q[1]) + UW'(y_sel);
		if (u_sum > SatHi) begin
			w_val = SatHi[B-1:0];
		end else if (u_sum < SatLo) begin
			w_val = SatLo[B-1:0];
		end else begin
			w_val = u_sum[B-1:0];
		end
	end

	assign k_zero = (j_q == '0) || (j_q >= n_q - 1'b1);
	assign shift_f = (j_q < n_q) ? $signed(f_rd) : '0;
	assign shift_k_a = k_zero ? '0 : $signed(a_rd);
	assign shift_k_b = k_zero ? '0 : $signed(b_rd);
	assign shift_k_c = k_zero ? '0 : $signed(c_rd);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (sample_accept && sample_item.final_point) begin
					state_d = (step_count_q == '0) ? ST_OUT_RD : ST_RD;
				end
			end
			ST_RD: state_d = ST_SHIFT;
			ST_SHIFT: state_d = ST_EVAL;
			ST_EVAL: begin
				if (j_q != '0 && interior) begin
					state_d = ST_MUL;
				end else begin
					state_d = run_done ? ST_OUT_RD : ST_RD;
				end
			end
			ST_MUL: state_d = ST_SCALE;
			ST_SCALE: begin
				if (stg_q == STG_SUM) begin
					state_d = ST_DIV;
				end else begin
					state_d = run_done ? ST_OUT_RD : ST_RD;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = run_done ? ST_OUT_RD : ST_RD;
				end
			end
			ST_OUT_RD: state_d = ST_OUT_SEND;
			ST_OUT_SEND: begin
				if (!result_stall) begin
					state_d = last_out ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		adv = 1'b0;
		f_we = 1'b0;
		f_waddr = i_addr;
		f_wdata = w_val;
		row_we = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				f_we = sample_accept && (loaded_q < CW'(MAX_POINTS));
				f_waddr = loaded_q[AW-1:0];
				f_wdata = sample_sat;
			end
			ST_EVAL: begin
				if (j_q == '0) begin
					adv = 1'b1;
				end else if (!interior) begin
					adv = 1'b1;
					if (stg_q == STG_SUM) begin
						f_we = 1'b1;
						f_wdata = '0;
					end
				end
			end
			ST_SCALE: begin
				if (stg_q == STG_SUM) begin
					div_start = 1'b1;
				end else begin
					adv = 1'b1;
					row_we = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					adv = 1'b1;
					f_we = 1'b1;
				end
			end
			default: begin
				adv = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			stg_q <= STG_K1;
			j_q <= '0;
			loaded_q <= '0;
			n_q <= '0;
			o_q <= '0;
			steps_q <= '0;
			courant_q <= CourantReset;
			step_count_q <= StepCountReset;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COURANT: courant_q <= cfg_data;
					CFG_STEPS: step_count_q <= cfg_data;
					default: courant_q <= courant_q;
				endcase
			end
			if (sample_accept) begin
				if (sample_item.final_point) begin
					n_q <= (loaded_q < CW'(MAX_POINTS)) ? loaded_q + 1'b1 : CW'(MAX_POINTS);
					loaded_q <= '0;
					j_q <= '0;
					stg_q <= STG_K1;
					steps_q <= '0;
					o_q <= '0;
				end else if (loaded_q < CW'(MAX_POINTS)) begin
					loaded_q <= loaded_q + 1'b1;
				end
			end
			if (adv) begin
				if (j_q == n_q) begin
					j_q <= '0;
					unique case (stg_q)
						STG_K1: stg_q <= STG_K2;
						STG_K2: stg_q <= STG_K3;
						STG_K3: stg_q <= STG_SUM;
						STG_SUM: begin
							stg_q <= STG_K1;
							steps_q <= steps_q + 16'd1;
						end
						default: stg_q <= STG_K1;
					endcase
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (state_q == ST_OUT_SEND && !result_stall) begin
				o_q <= o_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SHIFT) begin
			wf_q[0] <= wf_q[1];
			wf_q[1] <= wf_q[2];
			wf_q[2] <= shift_f;
			wa_q[0] <= wa_q[1];
			wa_q[1] <= wa_q[2];
			wa_q[2] <= shift_k_a;
			wb_q[0] <= wb_q[1];
			wb_q[1] <= wb_q[2];
			wb_q[2] <= shift_k_b;
			wc_q[0] <= wc_q[1];
			wc_q[1] <= wc_q[2];
			wc_q[2] <= shift_k_c;
		end
		if (state_q == ST_EVAL) begin
			s_q <= s_d;
		end
		if (state_q == ST_MUL) begin
			p_q <= MW'(s_q) * $signed(MW'({1'b0, courant_q}));
		end
	end

	assign out_ext = XW'($signed(f_rd));
	assign result_valid = (state_q == ST_OUT_SEND);
	assign result_item.result_value = out_ext[IoBits-1:0];
	assign result_item.last_of_row = last_out;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the RK4 heat equation stencil block.
// Loads rows, runs them, and checks every emitted point against a predictor.
// Depends on heat_rk4_pkg and heat_equation_rk4_stencil.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import heat_rk4_pkg::*;

	localparam int NoAcceptLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	in_item_t sample_item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result_item;
	logic cfg_we = 1'b0;
	logic [CfgIndexBits-1:0] cfg_index = '0;
	logic [CfgBits-1:0] cfg_data = '0;

	heat_equation_rk4_stencil u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample_item(sample_item),
		.result_valid(result_valid), .result_stall(result_stall), .result_item(result_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int send_idle_pct = 34;
	int recv_stall_pct = 54;
	int hold_token = 0;
	int errors = 0;
	int points_sent = 0;
	out_item_t point_q[$];

	// Predictor state.
	longint heat_row[MaxPoints];
	longint k1_row[MaxPoints];
	longint k2_row[MaxPoints];
	longint k3_row[MaxPoints];
	longint new_row[MaxPoints];
	int row_len = 0;
	longint courant = CourantReset;
	int steps = StepCountReset;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint lap_at(input longint r[MaxPoints], input int i);
		return r[i+1] - 2 * r[i] + r[i-1];
	endfunction

	function automatic longint round_scale(longint c, longint s, longint m, int k);
		longint d, num, q;
		d = m << k;
		num = c * s + d / 2;
		q = num / d;
		if (num % d != 0 && num < 0) q = q - 1;
		return q;
	endfunction

	task automatic advance_row(int n);
		longint sum;
		out_item_t o;
		for (int s = 0; s < steps; s++) begin
			k1_row[0] = 0; k2_row[0] = 0; k3_row[0] = 0;
			k1_row[n-1] = 0; k2_row[n-1] = 0; k3_row[n-1] = 0;
			for (int i = 1; i + 1 < n; i++)
				k1_row[i] = clamp32(heat_row[i] + round_scale(courant, lap_at(heat_row, i), 1, 17));
			for (int i = 1; i + 1 < n; i++)
				k2_row[i] = clamp32(heat_row[i] + round_scale(courant, lap_at(k1_row, i), 1, 17));
			for (int i = 1; i + 1 < n; i++)
				k3_row[i] = clamp32(heat_row[i] + round_scale(courant, lap_at(k2_row, i), 1, 16));
			for (int i = 1; i + 1 < n; i++) begin
				sum = lap_at(heat_row, i) + 2 * lap_at(k1_row, i) + 2 * lap_at(k2_row, i)
					+ lap_at(k3_row, i);
				new_row[i] = clamp32(heat_row[i] + round_scale(courant, sum, 3, 17));
			end
			for (int i = 1; i + 1 < n; i++)
				heat_row[i] = new_row[i];
			heat_row[0] = 0;
			heat_row[n-1] = 0;
		end
		for (int i = 0; i < n; i++) begin
			o.result_value = heat_row[i][31:0];
			o.last_of_row = (i + 1 == n);
			point_q.push_back(o);
		end
	endtask

	task automatic predict_point(in_item_t it);
		if (row_len < MaxPoints) begin
			heat_row[row_len] = longint'(it.sample_value);
			row_len++;
		end
		if (it.final_point) begin
			advance_row(row_len);
			row_len = 0;
		end
	endtask

	task automatic push_point(logic signed [31:0] v, logic fin);
		in_item_t it;
		it.sample_value = v;
		it.final_point = fin;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= it;
		do @(posedge clk); while (sample_stall);
		predict_point(it);
		points_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_row(int n);
		for (int i = 0; i < n; i++)
			push_point(pick_value(), i == n - 1);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (point_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CfgBits-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COURANT) courant = val;
		else steps = val;
		@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		push_point(32'sd1 <<< 29, 1'b0);
		push_point(-(32'sd1 <<< 28), 1'b0);
		push_point(32'sd12345, 1'b1);
		settle();
	endtask

	task automatic test_directed();
		write_reg(CFG_STEPS, 16'd0);
		push_point(32'h7FFF_FFFF, 1'b0);
		push_point(32'h8000_0000, 1'b0);
		push_point(32'h5555_5555, 1'b1);
		settle();
		write_reg(CFG_COURANT, 16'd65535);
		write_reg(CFG_STEPS, 16'd3);
		push_point(32'h7FFF_FFFF, 1'b0);
		push_point(32'h8000_0000, 1'b0);
		push_point(32'h7FFF_FFFF, 1'b0);
		push_point(32'h8000_0000, 1'b0);
		push_point(32'h7FFF_FFFF, 1'b1);
		push_point(32'h1234_5678, 1'b1);
		push_point(32'hDEAD_BEEF, 1'b0);
		push_point(32'h0BAD_F00D, 1'b1);
		settle();
		write_reg(CFG_COURANT, 16'd0);
		push_row(5);
		settle();
	endtask

	task automatic test_long_row();
		write_reg(CFG_COURANT, 16'd32768);
		write_reg(CFG_STEPS, 16'd2);
		push_row(MaxPoints + 2);
		settle();
	endtask

	task automatic test_backpressure();
		write_reg(CFG_STEPS, 16'd1);
		hold_token++;
		push_row(4);
		push_row(4);
		push_row(3);
		settle();
	endtask

	task automatic test_random_phase(int idle_in, int stall_out, int count);
		int target;
		send_idle_pct = idle_in;
		recv_stall_pct = stall_out;
		target = points_sent + count;
		while (points_sent < target) begin
			settle();
			write_reg(CFG_COURANT, $urandom_range(3) == 0 ? 16'd65535 : 16'($urandom));
			write_reg(CFG_STEPS, 16'($urandom_range(6)));
			repeat (4) begin
				if ($urandom_range(19) == 0) push_row($urandom_range(MaxPoints, 9));
				else push_row($urandom_range(8, 1));
			end
		end
		settle();
	endtask

	int hold_seen = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = 700;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (point_q.size() == 0) begin
				$display("%0t: unexpected point value=%h last=%b", $time,
					result_item.result_value, result_item.last_of_row);
				errors++;
			end else begin
				want = point_q.pop_front();
				if (result_item.result_value !== want.result_value) begin
					$display("%0t: value expected %h actual %h", $time,
						want.result_value, result_item.result_value);
					errors++;
				end
				if (result_item.last_of_row !== want.last_of_row) begin
					$display("%0t: last_of_row expected %b actual %b", $time,
						want.last_of_row, result_item.last_of_row);
					errors++;
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= NoAcceptLimit) begin
			$display("[heat_equation_rk4_stencil] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed();
		test_long_row();
		test_backpressure();
		test_random_phase(34, 54, 80);
		test_random_phase(54, 34, 80);
		test_random_phase(0, 0, 80);
		if (errors == 0)
			$display("[heat_equation_rk4_stencil] OK");
		else
			$display("[heat_equation_rk4_stencil] ERROR");
		$finish;
	end
endmodule
